// ===== hw/rtl/dmdc_pkg.sv =====
`default_nettype none

package dmdc_pkg;

    // Field and register widths
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned STATE_W   = 3;
    localparam int unsigned DRIVE_W   = 2;
    localparam int unsigned DEB_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_SPEED   = 1'd1;

    // Register reset values
    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd50;
    localparam logic [SPEED_W-1:0] FULL_SPEED     = 8'd255;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 2'd0,
        MODE_OPEN      = 2'd1,
        MODE_CLOSE     = 2'd2,
        MODE_POWER_OFF = 2'd3
    } t_mode;

    // Door states
    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED  = 3'd0,
        ST_OPENING = 3'd1,
        ST_OPEN    = 3'd2,
        ST_CLOSING = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_door_state;

    // Motor drive direction
    typedef enum logic [DRIVE_W-1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_BACK = 2'd2
    } t_drive;

    // Debounced switch levels handed to the door controller
    typedef struct packed {
        logic closed_stop;
        logic open_stop;
        logic btn_close;
        logic btn_open;
    } t_switches;

    // One result item
    typedef struct packed {
        t_door_state        door_state;
        logic               moving;
        logic               state_changed;
        t_drive             motor_drive;
        logic [SPEED_W-1:0] motor_speed;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/dmdc_debounce.sv =====
`default_nettype none

module dmdc_debounce #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_raw,
    input  wire logic [dmdc_pkg::DEB_W-1:0] i_limit,
    output logic                            o_level
);

    localparam int unsigned CMP_W =
        (COUNT_WIDTH > dmdc_pkg::DEB_W) ? COUNT_WIDTH : dmdc_pkg::DEB_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_prev;
    logic                   r_level;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic                   n_level;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       limit_ext;

    // Count ticks the reading has held, saturating
    always_comb begin
        if (i_raw != r_prev) begin
            n_cnt = '0;
        end else if (r_cnt == CNT_MAX) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
        cnt_ext   = CMP_W'(n_cnt);
        limit_ext = CMP_W'(i_limit);
        n_level   = (cnt_ext > limit_ext) ? i_raw : r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_level <= 1'b0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_prev  <= i_raw;
            r_level <= n_level;
            r_cnt   <= n_cnt;
        end
    end

    // Level as seen after this transaction's update
    assign o_level = n_level;

endmodule

`default_nettype wire

// ===== hw/rtl/dmdc_door.sv =====
`default_nettype none

module dmdc_door (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [dmdc_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [dmdc_pkg::SPEED_W-1:0] i_speed,
    input  wire logic                         i_ack,
    input  wire dmdc_pkg::t_switches          i_sw,
    input  wire logic [dmdc_pkg::SPEED_W-1:0] i_button_speed,
    output dmdc_pkg::t_result                 o_result
);

    dmdc_pkg::t_door_state        r_state, n_state;
    dmdc_pkg::t_door_state        r_acked, n_acked;
    dmdc_pkg::t_drive             r_drive, n_drive;
    logic [dmdc_pkg::SPEED_W-1:0] r_speed, n_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmdc_pkg::ST_UNKNOWN;
            r_acked <= dmdc_pkg::ST_UNKNOWN;
            r_drive <= dmdc_pkg::DRV_STOP;
            r_speed <= '0;
        end else if (i_en) begin
            r_state <= n_state;
            r_acked <= n_acked;
            r_drive <= n_drive;
            r_speed <= n_speed;
        end
    end

    // Command, then end stops, then buttons, then acknowledge
    always_comb begin
        n_state = r_state;
        n_drive = r_drive;
        n_speed = r_speed;

        case (dmdc_pkg::t_mode'(i_mode))
            dmdc_pkg::MODE_OPEN: begin
                n_drive = dmdc_pkg::DRV_BACK;
                n_speed = i_speed;
                n_state = dmdc_pkg::ST_OPENING;
            end
            dmdc_pkg::MODE_CLOSE: begin
                n_drive = dmdc_pkg::DRV_FWD;
                n_speed = i_speed;
                n_state = dmdc_pkg::ST_CLOSING;
            end
            dmdc_pkg::MODE_POWER_OFF: begin
                n_drive = dmdc_pkg::DRV_STOP;
                n_speed = '0;
            end
            default: begin
            end
        endcase

        // End stops only count while travelling towards them
        if (n_state == dmdc_pkg::ST_CLOSING && i_sw.closed_stop) begin
            n_drive = dmdc_pkg::DRV_STOP;
            n_speed = '0;
            n_state = dmdc_pkg::ST_CLOSED;
        end else if (n_state == dmdc_pkg::ST_OPENING && i_sw.open_stop) begin
            n_drive = dmdc_pkg::DRV_STOP;
            n_speed = '0;
            n_state = dmdc_pkg::ST_OPEN;
        end

        // Close button wins, even when closing is refused
        if (i_sw.btn_close) begin
            if (!(n_state inside {dmdc_pkg::ST_CLOSING, dmdc_pkg::ST_CLOSED})) begin
                n_drive = dmdc_pkg::DRV_FWD;
                n_speed = i_button_speed;
                n_state = dmdc_pkg::ST_CLOSING;
            end
        end else if (i_sw.btn_open) begin
            if (!(n_state inside {dmdc_pkg::ST_OPENING, dmdc_pkg::ST_OPEN})) begin
                n_drive = dmdc_pkg::DRV_BACK;
                n_speed = i_button_speed;
                n_state = dmdc_pkg::ST_OPENING;
            end
        end

        n_acked = i_ack ? n_state : r_acked;

        o_result.door_state    = n_state;
        o_result.moving        = (n_state inside {dmdc_pkg::ST_OPENING, dmdc_pkg::ST_CLOSING});
        o_result.state_changed = (n_state != r_acked);
        o_result.motor_drive   = n_drive;
        o_result.motor_speed   = n_speed;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/debounced_motor_door_controller_top.sv =====
// Door controller with debounced end stops and push buttons.
// Input channel: one transaction per timer tick (i_in_valid / o_in_stall),
// carrying the command, its speed, the change acknowledge and the four raw
// switch levels. Output channel: one result transaction per tick
// (o_out_valid / i_out_stall) with door state, moving flag, changed flag,
// motor drive and motor speed.
// Path: input register, then debounce and door logic into the result register.
// Throughput: 1 tick per cycle unless the output stalls; the combinational
// path through the four debouncers and door state update sets this figure.
// A stall on the output holds the result register; the input register then
// fills and o_in_stall rises in the same cycle it would otherwise drain.
// Reset (synchronous, active low): door state unknown, acknowledged state
// unknown, motor stopped, debouncers cleared, debounce ticks 50, button
// speed 255, both pipeline stages empty.
// Configuration writes are taken at any edge with i_cfg_we high; write
// them only while no transaction is in flight.
`default_nettype none

module debounced_motor_door_controller_top #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [dmdc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [dmdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dmdc_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [dmdc_pkg::SPEED_W-1:0]    i_speed,
    input  wire logic                            i_ack_change,
    input  wire logic                            i_open_end_stop,
    input  wire logic                            i_closed_end_stop,
    input  wire logic                            i_button_to_close,
    input  wire logic                            i_button_to_open,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [dmdc_pkg::STATE_W-1:0]         o_door_state,
    output logic                                 o_moving,
    output logic                                 o_state_changed,
    output logic [dmdc_pkg::DRIVE_W-1:0]         o_motor_drive,
    output logic [dmdc_pkg::SPEED_W-1:0]         o_motor_speed
);

    logic [dmdc_pkg::DEB_W-1:0]   r_debounce_ticks;
    logic [dmdc_pkg::SPEED_W-1:0] r_button_speed;

    logic                         r_in_valid;
    logic [dmdc_pkg::MODE_W-1:0]  r_mode;
    logic [dmdc_pkg::SPEED_W-1:0] r_speed;
    logic                         r_ack;
    logic [3:0]                   r_raw;

    logic                         r_out_valid;
    dmdc_pkg::t_result            r_result;

    logic                         advance;
    logic                         in_accept;
    dmdc_pkg::t_switches          sw;
    dmdc_pkg::t_result            result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= dmdc_pkg::DEBOUNCE_RESET;
            r_button_speed   <= dmdc_pkg::FULL_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dmdc_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_wdata;
                dmdc_pkg::CFG_BUTTON_SPEED:
                    r_button_speed <= i_cfg_wdata[dmdc_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: work stage advances when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= i_mode;
            r_speed <= i_speed;
            r_ack   <= i_ack_change;
            r_raw   <= {i_button_to_open, i_button_to_close,
                        i_open_end_stop, i_closed_end_stop};
        end
    end

    // Debouncers: closed stop, open stop, close button, open button
    dmdc_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_deb_closed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_raw   (r_raw[0]),
        .i_limit (r_debounce_ticks),
        .o_level (sw.closed_stop)
    );

    dmdc_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_deb_open (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_raw   (r_raw[1]),
        .i_limit (r_debounce_ticks),
        .o_level (sw.open_stop)
    );

    dmdc_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_deb_btn_close (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_raw   (r_raw[2]),
        .i_limit (r_debounce_ticks),
        .o_level (sw.btn_close)
    );

    dmdc_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_deb_btn_open (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_raw   (r_raw[3]),
        .i_limit (r_debounce_ticks),
        .o_level (sw.btn_open)
    );

    // Door state machine and motor control
    dmdc_door u_door (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_mode         (r_mode),
        .i_speed        (r_speed),
        .i_ack          (r_ack),
        .i_sw           (sw),
        .i_button_speed (r_button_speed),
        .o_result       (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_door_state    = r_result.door_state;
    assign o_moving        = r_result.moving;
    assign o_state_changed = r_result.state_changed;
    assign o_motor_drive   = r_result.motor_drive;
    assign o_motor_speed   = r_result.motor_speed;

endmodule

`default_nettype wire

// ===== hw/rtl/dmdc_checker.sv =====
`default_nettype none

module dmdc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [dmdc_pkg::STATE_W-1:0] o_door_state,
    input wire logic                         o_moving,
    input wire logic [dmdc_pkg::DRIVE_W-1:0] o_motor_drive,
    input wire logic [dmdc_pkg::SPEED_W-1:0] o_motor_speed
);

    // Moving flag agrees with the travelling states
    a_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_moving == ((o_door_state == dmdc_pkg::ST_OPENING) ||
                                      (o_door_state == dmdc_pkg::ST_CLOSING))))
        else $error("moving flag disagrees with door state");

    // A stopped motor has no speed
    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_motor_drive == dmdc_pkg::DRV_STOP)) |-> (o_motor_speed == '0))
        else $error("speed applied with motor stopped");

    // Resting at an end position means the motor is off
    a_rest_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_door_state == dmdc_pkg::ST_OPEN) ||
                         (o_door_state == dmdc_pkg::ST_CLOSED)))
        |-> (o_motor_drive == dmdc_pkg::DRV_STOP))
        else $error("motor driven at end position");

    // An empty result register never holds off the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_door_state) &&
                                          $stable(o_motor_speed)))
        else $error("stalled result changed");

endmodule

bind debounced_motor_door_controller_top dmdc_checker u_dmdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_door_state  (o_door_state),
    .o_moving      (o_moving),
    .o_motor_drive (o_motor_drive),
    .o_motor_speed (o_motor_speed)
);

`default_nettype wire

// ===== verif/door_checker.sv =====
`default_nettype none

// Watches both channels of the door controller, predicts each result from the
// accepted tick transactions and compares it with what the block returns.
module door_checker
    import dmdc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port, as driven into the block
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [SPEED_W-1:0]    i_speed,
    input  wire logic                  i_ack_change,
    input  wire logic                  i_open_end_stop,
    input  wire logic                  i_closed_end_stop,
    input  wire logic                  i_button_to_close,
    input  wire logic                  i_button_to_open,
    // output channel
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [STATE_W-1:0]    i_door_state,
    input  wire logic                  i_moving,
    input  wire logic                  i_state_changed,
    input  wire logic [DRIVE_W-1:0]    i_motor_drive,
    input  wire logic [SPEED_W-1:0]    i_motor_speed,
    // to the testbench top
    output int                         o_fail_count,
    output int                         o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // debouncer slots
    localparam int SLOT_CLOSED    = 0;
    localparam int SLOT_OPEN      = 1;
    localparam int SLOT_BTN_CLOSE = 2;
    localparam int SLOT_BTN_OPEN  = 3;

    localparam logic [COUNT_WIDTH-1:0] HELD_MAX = '1;

    // predicted state of the block
    logic [DEB_W-1:0]       deb_ticks;
    logic [SPEED_W-1:0]     btn_speed;
    t_door_state            door;
    t_door_state            acked;
    t_drive                 drive;
    logic [SPEED_W-1:0]     motor_spd;
    logic [3:0]             raw_last;
    logic [3:0]             level;
    logic [COUNT_WIDTH-1:0] held [4];

    t_result door_results_due [$];
    int      mismatches = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Works out the result of one tick and advances the predicted state
    function automatic t_result next_door_result(input t_mode cmd,
                                                 input logic [SPEED_W-1:0] cmd_speed,
                                                 input logic ack,
                                                 input logic [3:0] raw);
        t_result r;
        int s;
        // all four debouncers first
        for (s = 0; s < 4; s++) begin
            if (raw[s] != raw_last[s])
                held[s] = '0;
            else if (held[s] != HELD_MAX)
                held[s] = held[s] + 1'b1;
            if (64'(held[s]) > 64'(deb_ticks))
                level[s] = raw[s];
            raw_last[s] = raw[s];
        end
        // command
        case (cmd)
            MODE_OPEN: begin
                drive = DRV_BACK;
                motor_spd = cmd_speed;
                door = ST_OPENING;
            end
            MODE_CLOSE: begin
                drive = DRV_FWD;
                motor_spd = cmd_speed;
                door = ST_CLOSING;
            end
            MODE_POWER_OFF: begin
                drive = DRV_STOP;
                motor_spd = '0;
            end
            default: ;
        endcase
        // end stops only act on a moving door
        if (door == ST_CLOSING && level[SLOT_CLOSED]) begin
            drive = DRV_STOP;
            motor_spd = '0;
            door = ST_CLOSED;
        end else if (door == ST_OPENING && level[SLOT_OPEN]) begin
            drive = DRV_STOP;
            motor_spd = '0;
            door = ST_OPEN;
        end
        // close button wins, even when its request is refused
        if (level[SLOT_BTN_CLOSE]) begin
            if (door != ST_CLOSING && door != ST_CLOSED) begin
                drive = DRV_FWD;
                motor_spd = btn_speed;
                door = ST_CLOSING;
            end
        end else if (level[SLOT_BTN_OPEN]) begin
            if (door != ST_OPENING && door != ST_OPEN) begin
                drive = DRV_BACK;
                motor_spd = btn_speed;
                door = ST_OPENING;
            end
        end
        r.door_state    = door;
        r.moving        = (door == ST_OPENING || door == ST_CLOSING);
        r.state_changed = (door != acked);
        r.motor_drive   = drive;
        r.motor_speed   = motor_spd;
        // acknowledge lands after the flag is formed
        if (ack)
            acked = door;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Sample both channels at every edge
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        int s;
        if (!i_rst_n) begin
            deb_ticks = DEBOUNCE_RESET;
            btn_speed = FULL_SPEED;
            door      = ST_UNKNOWN;
            acked     = ST_UNKNOWN;
            drive     = DRV_STOP;
            motor_spd = '0;
            raw_last  = '0;
            level     = '0;
            for (s = 0; s < 4; s++)
                held[s] = '0;
            door_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_DEBOUNCE_TICKS)
                    deb_ticks = i_cfg_wdata[DEB_W-1:0];
                else if (i_cfg_addr == CFG_BUTTON_SPEED)
                    btn_speed = i_cfg_wdata[SPEED_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                want = next_door_result(t_mode'(i_mode), i_speed, i_ack_change,
                                        {i_button_to_open, i_button_to_close,
                                         i_open_end_stop, i_closed_end_stop});
                door_results_due.push_back(want);
            end
            if (i_out_valid === 1'b1 && !i_out_stall) begin
                if (door_results_due.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, door_state %0d",
                             $time, i_door_state);
                    mismatches++;
                end else begin
                    want = door_results_due.pop_front();
                    got.door_state    = t_door_state'(i_door_state);
                    got.moving        = i_moving;
                    got.state_changed = i_state_changed;
                    got.motor_drive   = t_drive'(i_motor_drive);
                    got.motor_speed   = i_motor_speed;
                    if (got.door_state !== want.door_state)
                        flag_mismatch("door_state", 8'(want.door_state),
                                      8'(got.door_state));
                    if (got.moving !== want.moving)
                        flag_mismatch("moving", 8'(want.moving), 8'(got.moving));
                    if (got.state_changed !== want.state_changed)
                        flag_mismatch("state_changed", 8'(want.state_changed),
                                      8'(got.state_changed));
                    if (got.motor_drive !== want.motor_drive)
                        flag_mismatch("motor_drive", 8'(want.motor_drive),
                                      8'(got.motor_drive));
                    if (got.motor_speed !== want.motor_speed)
                        flag_mismatch("motor_speed", want.motor_speed, got.motor_speed);
                end
            end
        end
        o_outstanding <= door_results_due.size();
        o_fail_count  <= mismatches;
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

// Drives tick transactions and configuration into the door controller and
// gives the verdict; all checking sits in door_checker.
module tb_top;

    import dmdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_WIDTH = 16;
    localparam int          CYCLE_LIMIT = 100000;
    localparam int          LONG_HOLD   = 64;

    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr        = CFG_DEBOUNCE_TICKS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata       = '0;
    logic                  i_in_valid        = 1'b0;
    logic [MODE_W-1:0]     i_mode            = MODE_TICK;
    logic [SPEED_W-1:0]    i_speed           = '0;
    logic                  i_ack_change      = 1'b0;
    logic                  i_open_end_stop   = 1'b0;
    logic                  i_closed_end_stop = 1'b0;
    logic                  i_button_to_close = 1'b0;
    logic                  i_button_to_open  = 1'b0;
    logic                  i_out_stall       = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATE_W-1:0]    o_door_state;
    logic                  o_moving;
    logic                  o_state_changed;
    logic [DRIVE_W-1:0]    o_motor_drive;
    logic [SPEED_W-1:0]    o_motor_speed;

    int   fail_count;
    int   outstanding;
    int   cycles     = 0;
    int   hold_left  = 0;
    bit   quiet_tx   = 1'b0;
    logic quiet_rx   = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;

    debounced_motor_door_controller_top #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_speed           (i_speed),
        .i_ack_change      (i_ack_change),
        .i_open_end_stop   (i_open_end_stop),
        .i_closed_end_stop (i_closed_end_stop),
        .i_button_to_close (i_button_to_close),
        .i_button_to_open  (i_button_to_open),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_door_state      (o_door_state),
        .o_moving          (o_moving),
        .o_state_changed   (o_state_changed),
        .o_motor_drive     (o_motor_drive),
        .o_motor_speed     (o_motor_speed)
    );

    door_checker #(.COUNT_WIDTH(COUNT_WIDTH)) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_speed           (i_speed),
        .i_ack_change      (i_ack_change),
        .i_open_end_stop   (i_open_end_stop),
        .i_closed_end_stop (i_closed_end_stop),
        .i_button_to_close (i_button_to_close),
        .i_button_to_open  (i_button_to_open),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_door_state      (o_door_state),
        .i_moving          (o_moving),
        .i_state_changed   (o_state_changed),
        .i_motor_drive     (o_motor_drive),
        .i_motor_speed     (o_motor_speed),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, quiet stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (quiet_rx) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 22);
        end
    end

    // Offer one tick transaction and wait until it is taken
    task automatic send_tick(input t_mode m, input logic [SPEED_W-1:0] spd,
                             input logic ack, input logic open_stop,
                             input logic closed_stop, input logic btn_close,
                             input logic btn_open);
        while (!quiet_tx && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= m;
        i_speed           <= spd;
        i_ack_change      <= ack;
        i_open_end_stop   <= open_stop;
        i_closed_end_stop <= closed_stop;
        i_button_to_close <= btn_close;
        i_button_to_open  <= btn_open;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
    endtask

    // Both registers, back to back; write enable stays high across the pair
    task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [SPEED_W-1:0] btn);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DEBOUNCE_TICKS;
        i_cfg_wdata <= deb;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_BUTTON_SPEED;
        i_cfg_wdata <= {8'($urandom_range(255)), btn};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Switch hold time: mostly long enough to be accepted, sometimes a bounce
    function automatic int hold_len(input int hold_base);
        if ($urandom_range(3) == 0)
            return $urandom_range(3, 1);
        return hold_base + $urandom_range(hold_base / 2 + 6, 2);
    endfunction

    // Random ticks with switch levels held for stretches
    task automatic run_random(input int count, input int hold_base);
        logic [3:0] lvl;
        int         left [4];
        int         k;
        int         pick;
        t_mode      m;
        lvl = '0;
        for (k = 0; k < 4; k++)
            left[k] = 0;
        repeat (count) begin
            for (k = 0; k < 4; k++) begin
                if (left[k] == 0) begin
                    // end stops half the time, buttons a third
                    lvl[k] = (k < 2) ? 1'($urandom_range(1)) : ($urandom_range(2) == 0);
                    left[k] = hold_len(hold_base);
                end
                left[k]--;
            end
            pick = $urandom_range(99);
            if (pick < 70)
                m = MODE_TICK;
            else if (pick < 80)
                m = MODE_OPEN;
            else if (pick < 90)
                m = MODE_CLOSE;
            else
                m = MODE_POWER_OFF;
            send_tick(m, 8'($urandom_range(255)), ($urandom_range(3) == 0),
                      lvl[1], lvl[0], lvl[2], lvl[3]);
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no debounce delay, so two equal readings are accepted
        write_regs(16'd0, 8'hA5);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // end stops while the state is still unknown
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // open command up to the open end stop
        send_tick(MODE_OPEN, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // power off keeps the door state
        send_tick(MODE_POWER_OFF, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // close at speed zero up to the closed end stop
        send_tick(MODE_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        // both buttons when closed: close refused, open still masked
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        // open button starts at button speed
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        // power off while opening, then a close command reversed by the button
        send_tick(MODE_POWER_OFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(MODE_CLOSE, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        // close button while opening
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        // everything high at once
        send_tick(MODE_POWER_OFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_tick(MODE_OPEN, 8'h01, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        drain_ticks();

        // Reset values, with a back-to-back stretch and the long hold-off
        write_regs(DEBOUNCE_RESET, FULL_SPEED);
        quiet_tx = 1'b1;
        hold_req <= 1'b1;
        run_random(200, 50);
        quiet_tx = 1'b0;
        run_random(400, 50);
        drain_ticks();

        // No debounce, button speed zero, result side never stalls
        write_regs(16'd0, 8'd0);
        quiet_rx <= 1'b1;
        run_random(300, 0);
        quiet_rx <= 1'b0;
        drain_ticks();

        write_regs(16'd3, 8'($urandom_range(255)));
        run_random(400, 3);
        drain_ticks();

        // Largest debounce count: no level change is ever accepted
        write_regs(16'hFFFF, FULL_SPEED);
        run_random(120, 20);
        drain_ticks();

        write_regs(16'd12, 8'd1);
        run_random(350, 12);
        drain_ticks();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
